FILE: hw/rtl/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg: shared types and constants of the track tessellator
// Point, span and result layouts, fixed-point widths and register map.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int MAX_STEPS_DEF = 32;
  localparam int QDEPTH_DEF    = 2;

  localparam int POS_W    = 32;
  localparam int FRM_W    = 16;
  localparam int POS_FRAC = 16;
  localparam int T_W      = POS_FRAC + 1;
  localparam int SPU_W    = 6;
  localparam int BASIS_SH = 19;
  localparam int ACC_SH   = 30;
  localparam int NCOMP    = 9;
  localparam int NPOS     = 3;
  localparam int NFRM     = 6;

  localparam int ADDR_W   = 3;
  localparam int PDATA_W  = 32;
  localparam logic [ADDR_W-1:0] ADDR_SPU  = 3'd0;
  localparam logic [SPU_W-1:0]  SPU_RESET = 6'd1;

  typedef struct packed {
    logic [NFRM-1:0][FRM_W-1:0] frm;
    logic [NPOS-1:0][POS_W-1:0] pos;
  } point_t;

  typedef struct packed {
    point_t [3:0] pt;
    logic         last;
  } span_t;

  typedef struct packed {
    logic [NFRM-1:0][FRM_W-1:0] frm;
    logic [NPOS-1:0][POS_W-1:0] pos;
    logic                       last;
  } result_t;

endpackage

FILE: hw/rtl/crt_queue.sv
// ----------------------------------------------------------------------------
// crt_queue: span queue
// Small first-in first-out buffer between the point front end and the
// interpolation back end.
// ----------------------------------------------------------------------------
module crt_queue #(
  parameter int W     = $bits(crt_pkg::span_t),
  parameter int DEPTH = crt_pkg::QDEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/crt_front.sv
// ----------------------------------------------------------------------------
// crt_front: control point front end
// Accepts control points, keeps the four-point window and queues one
// window snapshot for every span to be tessellated.
// ----------------------------------------------------------------------------
module crt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  crt_pkg::point_t in_pt,
  input  logic            in_end,
  input  logic            q_full,
  output logic            q_push,
  output crt_pkg::span_t  q_data
);

  typedef enum logic [1:0] {
    F_IN   = 2'b01,
    F_PUSH = 2'b10
  } front_state_t;

  localparam logic [1:0] PS_EMPTY = 2'd0;
  localparam logic [1:0] PS_ONE   = 2'd1;
  localparam logic [1:0] PS_MORE  = 2'd2;

  front_state_t          fstate;
  logic [1:0]            points_seen;
  logic                  end_pend;
  crt_pkg::point_t [3:0] win;
  logic                  accept;

  assign in_ready    = (fstate == F_IN);
  assign accept      = in_ready && in_valid;
  assign q_push      = (fstate == F_PUSH) && !q_full;
  assign q_data.pt   = win;
  // The span before a pending end-of-track span is not the last of its run.
  assign q_data.last = !end_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate      <= F_IN;
      points_seen <= PS_EMPTY;
      end_pend    <= 1'b0;
    end else begin
      case (fstate)
        F_IN: begin
          if (accept) begin
            case (points_seen)
              PS_EMPTY: begin
                points_seen <= in_end ? PS_EMPTY : PS_ONE;
              end
              PS_ONE: begin
                points_seen <= in_end ? PS_EMPTY : PS_MORE;
                end_pend    <= 1'b0;
                if (in_end) begin
                  fstate <= F_PUSH;
                end
              end
              default: begin
                points_seen <= in_end ? PS_EMPTY : PS_MORE;
                end_pend    <= in_end;
                fstate      <= F_PUSH;
              end
            endcase
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            if (end_pend) begin
              end_pend <= 1'b0;
            end else begin
              fstate <= F_IN;
            end
          end
        end
        default: begin
          fstate <= F_IN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((fstate == F_IN) && accept) begin
      case (points_seen)
        PS_EMPTY: begin
          win[0] <= in_pt;
          win[1] <= in_pt;
          win[2] <= in_pt;
        end
        PS_ONE: begin
          if (in_end) begin
            // Fill the last slot and shift once more, keeping that slot.
            win[0] <= win[1];
            win[1] <= win[2];
            win[2] <= in_pt;
            win[3] <= in_pt;
          end else begin
            win[3] <= in_pt;
          end
        end
        default: begin
          win[0] <= win[1];
          win[1] <= win[2];
          win[2] <= win[3];
          win[3] <= in_pt;
        end
      endcase
    end else if ((fstate == F_PUSH) && !q_full && end_pend) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
    end
  end

endmodule

FILE: hw/rtl/crt_back.sv
// ----------------------------------------------------------------------------
// crt_back: span interpolation back end
// Sizes each queued span, then evaluates the Catmull-Rom basis for every
// step and accumulates the nine output components on one multiplier.
// ----------------------------------------------------------------------------
module crt_back #(
  parameter int MAX_STEPS = crt_pkg::MAX_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [crt_pkg::SPU_W-1:0] spu,
  input  logic                      q_empty,
  input  crt_pkg::span_t            q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output crt_pkg::result_t          out_res
);

  localparam int POS_W  = crt_pkg::POS_W;
  localparam int FRAC   = crt_pkg::POS_FRAC;
  localparam int T_W    = crt_pkg::T_W;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int MAG_W  = $clog2(MAX_STEPS) + FRAC;
  localparam int SUM_W  = 2 * MAG_W + 2;
  localparam int LEN_W  = MAG_W + 1 - FRAC;
  localparam int PRD_W  = LEN_W + crt_pkg::SPU_W;
  localparam int DCNT_W = $clog2(T_W);
  localparam int W_W    = 3 * T_W + 3;
  localparam int ACC_W  = 2 * POS_W + 2;
  localparam int RQ_W   = ACC_W - crt_pkg::ACC_SH;

  localparam logic [POS_W:0]      MAG_LIM   = (POS_W + 1)'(MAX_STEPS) << FRAC;
  localparam logic [STEP_W-1:0]   STEPS_MAX = STEP_W'(MAX_STEPS);
  localparam logic [STEP_W-1:0]   STEPS_ONE = STEP_W'(1);
  localparam logic [PRD_W-1:0]    PRD_MAX   = PRD_W'(MAX_STEPS);
  localparam logic [DCNT_W-1:0]   DIV_LAST  = DCNT_W'(T_W - 1);
  localparam logic [SUM_W-1:0]    RBIT_INIT = SUM_W'(1) << (SUM_W - 2);
  localparam logic [3:0]          COMP_LAST = 4'(crt_pkg::NCOMP - 1);
  localparam logic [3:0]          NPOS_C    = 4'(crt_pkg::NPOS);
  localparam logic signed [W_W-1:0]   W_ONE2  = W_W'(1) << 49;
  localparam logic signed [W_W-1:0]   W_HALF  = W_W'(1) << (crt_pkg::BASIS_SH - 1);
  localparam logic signed [ACC_W-1:0] A_HALF  = ACC_W'(1) << (crt_pkg::ACC_SH - 1);
  localparam logic signed [RQ_W-1:0]  P_MAX   = RQ_W'(64'sd2147483647);
  localparam logic signed [RQ_W-1:0]  P_MIN   = -RQ_W'(64'sd2147483648);
  localparam logic signed [RQ_W-1:0]  F_MAX   = RQ_W'(64'sd32767);
  localparam logic signed [RQ_W-1:0]  F_MIN   = -RQ_W'(64'sd32768);

  typedef enum logic [11:0] {
    B_IDLE  = 12'b000000000001,
    B_MAG   = 12'b000000000010,
    B_SQ    = 12'b000000000100,
    B_ROOT  = 12'b000000001000,
    B_SCALE = 12'b000000010000,
    B_DIV   = 12'b000000100000,
    B_T     = 12'b000001000000,
    B_W1    = 12'b000010000000,
    B_W2    = 12'b000100000000,
    B_W3    = 12'b001000000000,
    B_MAC   = 12'b010000000000,
    B_OUT   = 12'b100000000000
  } back_state_t;

  back_state_t           bst;
  crt_pkg::point_t [3:0] cur_pt;
  logic                  cur_last;
  logic [1:0]            j;
  logic                  sat;
  logic [MAG_W-1:0]      mag [3];
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      rv;
  logic [SUM_W-1:0]      rr;
  logic [SUM_W-1:0]      rbit;
  logic [STEP_W-1:0]     steps;
  logic [STEP_W-1:0]     rem;
  logic [DCNT_W-1:0]     dcnt;
  logic [T_W-1:0]        q0;
  logic [STEP_W-1:0]     r0;
  logic [STEP_W-1:0]     k;
  logic [T_W-1:0]        t;
  logic [STEP_W-1:0]     tr;
  logic [2*T_W-1:0]      t2;
  logic [3*T_W-1:0]      t3;
  logic signed [POS_W-1:0] b [4];
  logic [3:0]            ic;
  logic [1:0]            ii;
  logic                  iss;
  logic                  p_v;
  logic [3:0]            p_c;
  logic [1:0]            p_i;
  logic signed [2*POS_W-1:0] prod;
  logic signed [ACC_W-1:0]   acc;
  logic                  a_v;
  logic [3:0]            a_c;
  crt_pkg::result_t      res;

  // Span length datapath.
  logic signed [POS_W:0] dif;
  logic [POS_W:0]        dabs;
  logic [SUM_W-1:0]      rt_try;
  logic [LEN_W-1:0]      len;
  logic [PRD_W-1:0]      lprod;
  logic [STEP_W:0]       remt;
  logic [STEP_W:0]       rs;

  assign dif    = (POS_W + 1)'($signed(cur_pt[2].pos[j])) -
                  (POS_W + 1)'($signed(cur_pt[1].pos[j]));
  assign dabs   = dif[POS_W] ? unsigned'(-dif) : unsigned'(dif);
  assign rt_try = rr + rbit;
  assign len    = rr[FRAC +: LEN_W];
  assign lprod  = PRD_W'(len) * PRD_W'(spu);
  assign remt   = {rem, (dcnt == '0)};
  assign rs     = {1'b0, tr} + {1'b0, r0};

  // Basis weights from t, t^2 and t^3, rounded to Q2.30.
  logic signed [W_W-1:0] t3e, t2s, ts;
  logic signed [W_W-1:0] w [4];

  assign t3e  = W_W'(t3);
  assign t2s  = W_W'(t2) << FRAC;
  assign ts   = W_W'(t) << (2 * FRAC);
  assign w[0] = (t2s <<< 1) - t3e - ts + W_HALF;
  assign w[1] = t3e + (t3e <<< 1) - (t2s <<< 2) - t2s + W_ONE2 + W_HALF;
  assign w[2] = (t2s <<< 2) - t3e - (t3e <<< 1) + ts + W_HALF;
  assign w[3] = t3e - t2s + W_HALF;

  // Multiply operand: a position word or a sign-extended frame word.
  logic [2:0]              fidx;
  logic signed [POS_W-1:0] op;

  assign fidx = (ic < NPOS_C) ? 3'd0 : 3'(ic - NPOS_C);
  assign op   = (ic < NPOS_C) ? $signed(cur_pt[ii].pos[ic[1:0]])
                              : POS_W'($signed(cur_pt[ii].frm[fidx]));

  // Rounding and saturation of a finished component.
  logic signed [ACC_W-1:0] rnd;
  logic signed [RQ_W-1:0]  rq;
  logic [POS_W-1:0]        sat_pos;
  logic [crt_pkg::FRM_W-1:0] sat_frm;
  logic [2:0]              aidx;

  assign rnd     = acc + A_HALF;
  assign rq      = rnd[ACC_W-1:crt_pkg::ACC_SH];
  assign sat_pos = (rq > P_MAX) ? P_MAX[POS_W-1:0] :
                   (rq < P_MIN) ? P_MIN[POS_W-1:0] : rq[POS_W-1:0];
  assign sat_frm = (rq > F_MAX) ? F_MAX[crt_pkg::FRM_W-1:0] :
                   (rq < F_MIN) ? F_MIN[crt_pkg::FRM_W-1:0] : rq[crt_pkg::FRM_W-1:0];
  assign aidx    = (a_c < NPOS_C) ? 3'd0 : 3'(a_c - NPOS_C);

  assign q_pop = (bst == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      bst       <= B_IDLE;
      out_valid <= 1'b0;
      iss       <= 1'b0;
      p_v       <= 1'b0;
      a_v       <= 1'b0;
    end else begin
      if (out_valid && out_ready && (bst != B_OUT)) begin
        out_valid <= 1'b0;
      end
      p_v <= iss;
      a_v <= p_v && (p_i == 2'd3);
      if (iss && (ii == 2'd3) && (ic == COMP_LAST)) begin
        iss <= 1'b0;
      end
      case (bst)
        B_IDLE:  if (!q_empty) bst <= B_MAG;
        B_MAG:   if (j == 2'd2) bst <= B_SQ;
        B_SQ:    if (j == 2'd2) bst <= B_ROOT;
        B_ROOT:  if (rbit[0]) bst <= B_SCALE;
        B_SCALE: bst <= B_DIV;
        B_DIV:   if (dcnt == DIV_LAST) bst <= B_T;
        B_T:     bst <= B_W1;
        B_W1:    bst <= B_W2;
        B_W2:    bst <= B_W3;
        B_W3:    bst <= B_MAC;
        B_MAC: begin
          // Issue starts once the weights are loaded.
          if (!iss && !p_v && !a_v) begin
            iss <= 1'b1;
          end
          if (a_v && (a_c == COMP_LAST)) begin
            bst <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            bst       <= (k == steps) ? B_IDLE : B_T;
          end
        end
        default: bst <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (bst)
      B_IDLE: begin
        cur_pt   <= q_head.pt;
        cur_last <= q_head.last;
        j        <= 2'd0;
        sat      <= 1'b0;
        sum      <= '0;
      end
      B_MAG: begin
        // A component gap of MAX_STEPS units or more saturates the step count.
        if (dabs >= MAG_LIM) begin
          sat <= 1'b1;
        end
        mag[j] <= dabs[MAG_W-1:0];
        j      <= (j == 2'd2) ? 2'd0 : j + 2'd1;
      end
      B_SQ: begin
        sum  <= sum + SUM_W'(mag[j] * mag[j]);
        j    <= j + 2'd1;
        rv   <= sum + SUM_W'(mag[j] * mag[j]);
        rr   <= '0;
        rbit <= RBIT_INIT;
      end
      B_ROOT: begin
        if (rv >= rt_try) begin
          rv <= rv - rt_try;
          rr <= (rr >> 1) + rbit;
        end else begin
          rr <= rr >> 1;
        end
        rbit <= rbit >> 2;
      end
      B_SCALE: begin
        if (spu == '0) begin
          steps <= STEPS_ONE;
        end else if (sat || (lprod > PRD_MAX)) begin
          steps <= STEPS_MAX;
        end else if (lprod == '0) begin
          steps <= STEPS_ONE;
        end else begin
          steps <= lprod[STEP_W-1:0];
        end
        rem  <= '0;
        dcnt <= '0;
      end
      B_DIV: begin
        // One quotient bit of 2^16 / steps per cycle.
        if (remt >= {1'b0, steps}) begin
          rem <= STEP_W'(remt - {1'b0, steps});
          q0  <= {q0[T_W-2:0], 1'b1};
        end else begin
          rem <= remt[STEP_W-1:0];
          q0  <= {q0[T_W-2:0], 1'b0};
        end
        dcnt <= dcnt + 1'b1;
        if (dcnt == DIV_LAST) begin
          t  <= '0;
          tr <= '0;
          k  <= '0;
        end
      end
      B_T: begin
        // The division remainder is taken before the first step of a span.
        if (k == '0) begin
          r0 <= rem;
        end
        k <= k + 1'b1;
      end
      B_W1: begin
        // t advances by q0 plus a carried remainder, giving floor(k*2^16/steps).
        if (rs >= {1'b0, steps}) begin
          tr <= STEP_W'(rs - {1'b0, steps});
          t  <= t + q0 + 1'b1;
        end else begin
          tr <= rs[STEP_W-1:0];
          t  <= t + q0;
        end
      end
      B_W2: begin
        t2 <= t * t;
      end
      B_W3: begin
        t3 <= t2 * (2 * T_W)'(t);
        ic <= '0;
        ii <= '0;
      end
      B_MAC: begin
        if (iss) begin
          ii <= ii + 2'd1;
          if (ii == 2'd3) begin
            ic <= ic + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (bst == B_OUT && (!out_valid || out_ready)) begin
      out_res.pos  <= res.pos;
      out_res.frm  <= res.frm;
      out_res.last <= cur_last && (k == steps);
    end
    // Weights are taken in the cycle after t^3 is ready.
    if (bst == B_MAC && !iss && !p_v && !a_v) begin
      b[0] <= w[0][crt_pkg::BASIS_SH +: POS_W];
      b[1] <= w[1][crt_pkg::BASIS_SH +: POS_W];
      b[2] <= w[2][crt_pkg::BASIS_SH +: POS_W];
      b[3] <= w[3][crt_pkg::BASIS_SH +: POS_W];
    end
    p_c  <= ic;
    p_i  <= ii;
    prod <= op * b[ii];
    acc  <= ((p_i == 2'd0) ? ACC_W'(0) : acc) + ACC_W'(prod);
    a_c  <= p_c;
    if (a_v) begin
      if (a_c < NPOS_C) begin
        res.pos[a_c[1:0]] <= sat_pos;
      end else begin
        res.frm[aidx] <= sat_frm;
      end
    end
  end

endmodule

FILE: hw/rtl/catmull_rom_track_tessellator.sv
// ----------------------------------------------------------------------------
// catmull_rom_track_tessellator: Catmull-Rom track tessellation top level
// Control point intake, span queue, interpolation engine and the
// configuration register.
// ----------------------------------------------------------------------------
// Control points arrive one per input transfer; the front end keeps a
// four-point window (the first point of a track repeated at the front, the
// last at the end) and queues one window snapshot per span, while the back
// end sizes each span and emits its interpolated points in order, the last
// one of each input flagged with last_of_run. A first point and an unended
// second point produce nothing. Per span the back end first runs a setup
// dominated by a bit-serial square root (one result bit per cycle) and a
// serial divider that yields the step increment of t. Each interpolated
// point then goes through the steps for t, t^2, t^3 and the basis weights,
// and through 36 products plus pipeline drain on the single 32x32
// multiply-accumulate unit, which evaluates the three position and six
// frame components in turn. A finished point waits in the output register
// while the next one is computed. The two-entry span queue lets the front
// end accept the next control point while the back end is still busy.
// steps_per_unit lies at byte address 0 of the configuration port and
// should be written only while the block is idle.
// ----------------------------------------------------------------------------
module catmull_rom_track_tessellator #(
  parameter int MAX_STEPS = crt_pkg::MAX_STEPS_DEF,
  parameter int QDEPTH    = crt_pkg::QDEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crt_pkg::ADDR_W-1:0]  paddr,
  input  logic [crt_pkg::PDATA_W-1:0] pwdata,
  output logic [crt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // Control point channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  input  logic signed [15:0]          right_x,
  input  logic signed [15:0]          right_y,
  input  logic signed [15:0]          right_z,
  input  logic signed [15:0]          up_x,
  input  logic signed [15:0]          up_y,
  input  logic signed [15:0]          up_z,
  input  logic                        end_of_track,
  // Interpolated point channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          tween_x,
  output logic signed [31:0]          tween_y,
  output logic signed [31:0]          tween_z,
  output logic signed [15:0]          tween_right_x,
  output logic signed [15:0]          tween_right_y,
  output logic signed [15:0]          tween_right_z,
  output logic signed [15:0]          tween_up_x,
  output logic signed [15:0]          tween_up_y,
  output logic signed [15:0]          tween_up_z,
  output logic                        last_of_run
);

  localparam int SPAN_W = $bits(crt_pkg::span_t);

  logic [crt_pkg::SPU_W-1:0] spu;
  logic                      cfg_wr;

  crt_pkg::point_t  in_pt;
  crt_pkg::span_t   q_wdata;
  crt_pkg::span_t   q_head;
  logic [SPAN_W-1:0] q_rdata;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  crt_pkg::result_t res;

  // The register is written in the access phase of a write transfer; the
  // port never inserts wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == crt_pkg::ADDR_SPU);
  assign prdata = (paddr == crt_pkg::ADDR_SPU) ?
                  crt_pkg::PDATA_W'(spu) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spu <= crt_pkg::SPU_RESET;
    end else if (cfg_wr) begin
      spu <= pwdata[crt_pkg::SPU_W-1:0];
    end
  end

  assign in_pt.pos = {pos_z, pos_y, pos_x};
  assign in_pt.frm = {up_z, up_y, up_x, right_z, right_y, right_x};

  crt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pt    (in_pt),
    .in_end   (end_of_track),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  crt_queue #(
    .W     (SPAN_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_head = q_rdata;

  crt_back #(
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .spu       (spu),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign tween_x       = res.pos[0];
  assign tween_y       = res.pos[1];
  assign tween_z       = res.pos[2];
  assign tween_right_x = res.frm[0];
  assign tween_right_y = res.frm[1];
  assign tween_right_z = res.frm[2];
  assign tween_up_x    = res.frm[3];
  assign tween_up_y    = res.frm[4];
  assign tween_up_z    = res.frm[5];
  assign last_of_run   = res.last;

endmodule

FILE: hw/rtl/crt_checker.sv
// ----------------------------------------------------------------------------
// crt_checker: port-level checks for the track tessellator
// Watches the configuration port and the result channel over time.
// ----------------------------------------------------------------------------
module crt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [crt_pkg::ADDR_W-1:0]  paddr,
  input logic [crt_pkg::PDATA_W-1:0] pwdata,
  input logic [crt_pkg::PDATA_W-1:0] prdata,
  input logic                        pready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [31:0]          tween_x,
  input logic                        last_of_run
);

  // The port never stalls a transfer.
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  // Reset empties the result register.
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A written rate reads back on the next cycle.
  a_cfg_rb: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr == crt_pkg::ADDR_SPU) |=>
    (paddr != crt_pkg::ADDR_SPU ||
     prdata == crt_pkg::PDATA_W'($past(pwdata[crt_pkg::SPU_W-1:0]))))
    else $error("configuration readback mismatch");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
    (out_valid && $stable(tween_x) && $stable(last_of_run)))
    else $error("result changed while stalled");

endmodule

bind catmull_rom_track_tessellator crt_checker u_crt_checker (
  .clk         (clk),
  .rst         (rst),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .tween_x     (tween_x),
  .last_of_run (last_of_run)
);

FILE: sim/crt_tessellator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_tessellator_checker: result predictor and scoreboard
// Watches the configuration port and both point channels of the track
// tessellator, predicts every interpolated point and compares in order.
// ----------------------------------------------------------------------------
module crt_tessellator_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crt_pkg::ADDR_W-1:0]  paddr,
  input  logic [crt_pkg::PDATA_W-1:0] pwdata,
  input  logic                        pready,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  input  logic signed [15:0]          right_x,
  input  logic signed [15:0]          right_y,
  input  logic signed [15:0]          right_z,
  input  logic signed [15:0]          up_x,
  input  logic signed [15:0]          up_y,
  input  logic signed [15:0]          up_z,
  input  logic                        end_of_track,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [31:0]          tween_x,
  input  logic signed [31:0]          tween_y,
  input  logic signed [31:0]          tween_z,
  input  logic signed [15:0]          tween_right_x,
  input  logic signed [15:0]          tween_right_y,
  input  logic signed [15:0]          tween_right_z,
  input  logic signed [15:0]          tween_up_x,
  input  logic signed [15:0]          tween_up_y,
  input  logic signed [15:0]          tween_up_z,
  input  logic                        last_of_run,
  output int                          errors,
  output int                          pending
);

  localparam int STEP_LIMIT = 32;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [5:0][15:0] frm;
    logic             last;
  } tween_t;

  tween_t  tween_q[$];
  longint  win_pos[12];
  longint  win_frm[24];
  int      fill;
  logic [crt_pkg::SPU_W-1:0] rate;

  const string pos_name[3] = '{"tween_x", "tween_y", "tween_z"};
  const string frm_name[6] = '{"tween_right_x", "tween_right_y", "tween_right_z",
                               "tween_up_x", "tween_up_y", "tween_up_z"};

  task automatic report(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Step count of the span between window slots 1 and 2.
  function automatic int span_steps();
    longint unsigned sum, mag, s;
    longint d;
    sum = 0;
    if (rate == 0) return 1;
    for (int j = 0; j < 3; j++) begin
      d = win_pos[6 + j] - win_pos[3 + j];
      mag = (d < 0) ? -d : d;
      if (mag >= (longint'(STEP_LIMIT) << 16)) return STEP_LIMIT;
      sum += mag * mag;
    end
    s = (sqrt_floor(sum) >> 16) * rate;
    if (s > STEP_LIMIT) s = STEP_LIMIT;
    if (s < 1) s = 1;
    return int'(s);
  endfunction

  task automatic shift_window();
    for (int i = 0; i < 9; i++) win_pos[i] = win_pos[i + 3];
    for (int i = 0; i < 18; i++) win_frm[i] = win_frm[i + 6];
  endtask

  task automatic place(int slot, longint p[3], longint f[6]);
    for (int j = 0; j < 3; j++) win_pos[slot * 3 + j] = p[j];
    for (int j = 0; j < 6; j++) win_frm[slot * 6 + j] = f[j];
  endtask

  // Appends the interpolated points of one span; returns how many.
  function automatic int tessellate_span();
    int     steps;
    longint t, t2, t3, acc;
    longint w[4], b[4];
    tween_t r;
    steps = span_steps();
    for (int k = 1; k <= steps; k++) begin
      t  = (longint'(k) << 16) / steps;
      t2 = t * t;
      t3 = t2 * t;
      w[0] = -t3 + 2 * t2 * 65536 - t * (longint'(1) << 32);
      w[1] = 3 * t3 - 5 * t2 * 65536 + 2 * (longint'(1) << 48);
      w[2] = -3 * t3 + 4 * t2 * 65536 + t * (longint'(1) << 32);
      w[3] = t3 - t2 * 65536;
      for (int i = 0; i < 4; i++)
        b[i] = (w[i] + (longint'(1) << 18)) >>> crt_pkg::BASIS_SH;
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += win_pos[i * 3 + j] * b[i];
        acc = clip((acc + (longint'(1) << 29)) >>> crt_pkg::ACC_SH,
                   -64'sd2147483648, 64'sd2147483647);
        r.pos[j] = acc[31:0];
      end
      for (int j = 0; j < 6; j++) begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += win_frm[i * 6 + j] * b[i];
        acc = clip((acc + (longint'(1) << 29)) >>> crt_pkg::ACC_SH, -32768, 32767);
        r.frm[j] = acc[15:0];
      end
      r.last = 1'b0;
      tween_q = {tween_q, r};
    end
    return steps;
  endfunction

  task automatic absorb_point(longint p[3], longint f[6], logic fin);
    int n;
    n = 0;
    if (fill == 0) begin
      place(0, p, f);
      place(1, p, f);
      place(2, p, f);
      fill = fin ? 0 : 1;
      return;
    end
    if (fill == 1) begin
      place(3, p, f);
      fill = 2;
    end else begin
      shift_window();
      place(3, p, f);
      n += tessellate_span();
    end
    if (fin) begin
      shift_window();
      n += tessellate_span();
      fill = 0;
    end
    if (n > 0) tween_q[tween_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    longint p[3], f[6];
    tween_t got, exp_r;
    if (rst) begin
      for (int i = 0; i < 12; i++) win_pos[i] = 0;
      for (int i = 0; i < 24; i++) win_frm[i] = 0;
      fill = 0;
      rate = crt_pkg::SPU_RESET;
      tween_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == crt_pkg::ADDR_SPU)
        rate = pwdata[crt_pkg::SPU_W-1:0];
      if (out_valid && out_ready) begin
        got.pos  = {tween_z, tween_y, tween_x};
        got.frm  = {tween_up_z, tween_up_y, tween_up_x,
                    tween_right_z, tween_right_y, tween_right_x};
        got.last = last_of_run;
        if (tween_q.size() == 0) begin
          report("result transfer with no point expected");
        end else begin
          exp_r = tween_q.pop_front();
          for (int j = 0; j < 3; j++)
            if (got.pos[j] !== exp_r.pos[j])
              report($sformatf("%s expected %0d got %0d", pos_name[j],
                     $signed(exp_r.pos[j]), $signed(got.pos[j])));
          for (int j = 0; j < 6; j++)
            if (got.frm[j] !== exp_r.frm[j])
              report($sformatf("%s expected %0d got %0d", frm_name[j],
                     $signed(exp_r.frm[j]), $signed(got.frm[j])));
          if (got.last !== exp_r.last)
            report($sformatf("last_of_run expected %0b got %0b", exp_r.last, got.last));
        end
      end
      if (in_valid && in_ready) begin
        p = '{longint'(pos_x), longint'(pos_y), longint'(pos_z)};
        f = '{longint'(right_x), longint'(right_y), longint'(right_z),
              longint'(up_x), longint'(up_y), longint'(up_z)};
        absorb_point(p, f, end_of_track);
      end
    end
    pending = tween_q.size();
  end

endmodule

FILE: sim/tb_catmull_rom_track_tessellator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_catmull_rom_track_tessellator: track tessellator testbench
// Feeds directed and random tracks under several step rates with random
// stalls on both channels; the checker predicts and compares every point.
// ----------------------------------------------------------------------------
module tb_catmull_rom_track_tessellator;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [crt_pkg::ADDR_W-1:0]  paddr = '0;
  logic [crt_pkg::PDATA_W-1:0] pwdata = '0;
  logic [crt_pkg::PDATA_W-1:0] prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [31:0]  pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0]  right_x = '0, right_y = '0, right_z = '0;
  logic signed [15:0]  up_x = '0, up_y = '0, up_z = '0;
  logic                end_of_track = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [31:0]  tween_x, tween_y, tween_z;
  logic signed [15:0]  tween_right_x, tween_right_y, tween_right_z;
  logic signed [15:0]  tween_up_x, tween_up_y, tween_up_z;
  logic                last_of_run;

  int   errors, pending;
  logic point_taken = 1'b0;
  bit   hold_req = 1'b0;

  // Current control point; the random walk keeps the previous one here.
  logic signed [31:0] cur_pos[3];
  logic signed [15:0] cur_frm[6];

  always #10 clk = ~clk;

  catmull_rom_track_tessellator dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .pos_x, .pos_y, .pos_z, .right_x, .right_y, .right_z,
    .up_x, .up_y, .up_z, .end_of_track,
    .out_valid, .out_ready, .tween_x, .tween_y, .tween_z,
    .tween_right_x, .tween_right_y, .tween_right_z,
    .tween_up_x, .tween_up_y, .tween_up_z, .last_of_run
  );

  crt_tessellator_checker checker_i (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_ready, .pos_x, .pos_y, .pos_z, .right_x, .right_y, .right_z,
    .up_x, .up_y, .up_z, .end_of_track,
    .out_valid, .out_ready, .tween_x, .tween_y, .tween_z,
    .tween_right_x, .tween_right_y, .tween_right_z,
    .tween_up_x, .tween_up_y, .tween_up_z, .last_of_run,
    .errors, .pending
  );

  // Registered view of the input handshake, so that the sender reads it at
  // the falling edge without racing the block's own updates.
  always @(posedge clk) point_taken <= in_valid && in_ready && !rst;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers cur_pos/cur_frm as one point and waits for its transfer.
  task automatic send_point(logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pos_x <= cur_pos[0];  pos_y <= cur_pos[1];  pos_z <= cur_pos[2];
    right_x <= cur_frm[0]; right_y <= cur_frm[1]; right_z <= cur_frm[2];
    up_x <= cur_frm[3];    up_y <= cur_frm[4];    up_z <= cur_frm[5];
    end_of_track <= fin;
    in_valid <= 1'b1;
    @(negedge clk);
    while (!point_taken) @(negedge clk);
  endtask

  // Stops offering points, waits until every predicted point came out, and
  // then lets the back end settle in case the last point produced nothing.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_rate(int unsigned v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= crt_pkg::ADDR_SPU;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_point(int x, int y, int z, int unsigned frm_bits);
    cur_pos = '{x, y, z};
    for (int j = 0; j < 6; j++) cur_frm[j] = frm_bits[15:0];
  endtask

  task automatic random_frame();
    for (int j = 0; j < 6; j++) cur_frm[j] = 16'($urandom());
  endtask

  // Step between neighboring points: mostly below one unit, so that spans
  // stay short, some of a few units, a few far enough to saturate steps.
  function automatic int walk_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return int'($urandom_range(0, 2 * 58982)) - 58982;
    if (r < 92) return int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
    if (r < 98) return int'($urandom_range(0, 80 * 65536)) - 40 * 65536;
    return $urandom();
  endfunction

  // Sends whole tracks of one to six points until at least count points are sent.
  task automatic run_tracks(int count);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0)
        cur_pos = '{$urandom(), $urandom(), $urandom()};
      else
        for (int j = 0; j < 3; j++)
          cur_pos[j] = int'($urandom_range(0, 2000 << 16)) - (1000 << 16);
      for (int n = 0; n < len; n++) begin
        if (n > 0) begin
          if ($urandom_range(0, 19) == 0)
            cur_pos = '{$urandom(), $urandom(), $urandom()};
          else
            for (int j = 0; j < 3; j++) cur_pos[j] = cur_pos[j] + walk_delta();
        end
        random_frame();
        send_point(n == len - 1);
      end
      sent += len;
    end
  endtask

  // Receiver: random ready stretches and stalls, with one long hold-off
  // on request so that the block fills and pushes back on its input.
  initial begin
    int r;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
        r = $urandom_range(0, 99);
        if (r < 25) begin
          // No stall this time: a stretch of back-to-back transfers.
          repeat ($urandom_range(20, 80)) @(negedge clk);
        end else begin
          out_ready <= 1'b0;
          if (r < 92) repeat ($urandom_range(1, 3)) @(negedge clk);
          else repeat ($urandom_range(20, 60)) @(negedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned rates[6];
    rates = '{0, 32, 1, 5, $urandom_range(2, 31), 3};
    cur_pos = '{0, 0, 0};
    cur_frm = '{0, 0, 0, 0, 0, 0};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset rate of one step per unit.
    // A track of a single point produces nothing.
    set_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h4000);
    send_point(1'b1);
    // A two-point track yields exactly one span from its end point.
    set_point(0, 0, 0, 16'h4000);
    send_point(1'b0);
    set_point(3 << 16, 4 << 16, 0, 16'hC000);
    send_point(1'b1);
    // Extreme positions and frames: saturation of steps and of the outputs.
    set_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
    send_point(1'b0);
    set_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
    send_point(1'b0);
    set_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF);
    send_point(1'b0);
    set_point(-1, -1, -1, 16'hFFFF);
    send_point(1'b1);
    // A longer track with steps of a few units and mixed frames.
    set_point(0, 0, 0, 16'h0000);
    for (int n = 0; n < 6; n++) begin
      cur_pos[0] = cur_pos[0] + (n << 16) + 16'h8000;
      cur_pos[1] = cur_pos[1] - (2 << 16);
      random_frame();
      send_point(n == 5);
    end
    // Exactly 32 units apart: steps saturate on one component directly.
    set_point(0, 0, 0, 16'h2000);
    send_point(1'b0);
    set_point(32 << 16, 0, 0, 16'hE000);
    send_point(1'b0);
    set_point(32 << 16, 1 << 16, 0, 16'h1234);
    send_point(1'b1);

    // Random phases, each under its own step rate; the receiver holds off
    // for a long stretch at the start of the third phase.
    foreach (rates[i]) begin
      drain();
      write_rate(rates[i]);
      if (i == 2) hold_req = 1'b1;
      run_tracks(70);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("Verification failed");
    $finish;
  end

endmodule
